// ----- hw/rtl/assert_macros.svh -----
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property holds at every clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// condition never holds outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)

`endif

`endif

// ----- hw/rtl/sqe_pkg.sv -----
package sqe_pkg;

   localparam int FAR_SHIFT = 15;

   // quotient magnitude never exceeds 2^(FAR_SHIFT+8)
   localparam int QUO_W     = FAR_SHIFT + 9;
   localparam int CNT_W     = $clog2(QUO_W);

   localparam int VTX_W     = 30;
   localparam int DLT_W     = 31;
   localparam int LEN_W     = 32;
   localparam int REM_W     = 33;
   localparam int CRN_W     = 32;
   localparam int COL_W     = 32;
   localparam int PROD_W    = 2 * DLT_W;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 96;

   localparam logic [LEN_W-1:0] MIN_LEN = LEN_W'(256);

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_X = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_LIGHT_Y = 1'b1;

   localparam logic [1:0] CORNER_PREV_VTX = 2'd0;
   localparam logic [1:0] CORNER_PREV_FAR = 2'd1;
   localparam logic [1:0] CORNER_CUR_FAR  = 2'd2;
   localparam logic [1:0] CORNER_CUR_VTX  = 2'd3;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_LEN   = 7'b0000010,
      ST_DIV   = 7'b0000100,
      ST_MUL_A = 7'b0001000,
      ST_MUL_B = 7'b0010000,
      ST_CMP   = 7'b0100000,
      ST_EMIT  = 7'b1000000
   } state_type;

endpackage

// ----- hw/rtl/shadow_quad_extruder.sv -----
// channel | dir | handshake            | payload
// req     | in  | req_tvalid/tready    | tdata: vertex_x, vertex_y, shadow_color; tuser: start
// rsp     | out | rsp_tvalid/tready    | tdata: corner_x, corner_y, corner_color; tlast: last
// csr     | in  | csr_valid/csr_ready  | csr_index, csr_data (light origin x / y)
//
// a vertex passes the length step and the bit-serial divider, which runs once per axis, then the
// cross-product multiplies and the compare before any corner goes out; the quad's four corners follow.
// a vertex that is too close or emits no quad skips the divider or the output phase.
// reset is synchronous, active high; it clears the light origin and the previous vertex.
// corners sit in an output register; a stall there holds the sequencer in the output phase.
`include "assert_macros.svh"

module shadow_quad_extruder
   import sqe_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // [29:0] vertex_x, [59:30] vertex_y, [91:60] shadow_color, [95:92] zero
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // [0] polygon_start
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [31:0] corner_x, [63:32] corner_y, [95:64] corner_color
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [VTX_W-1:0]       csr_data
);

   state_type state_ff, state_in;

   logic signed [VTX_W-1:0] light_x_ff, light_x_in;
   logic signed [VTX_W-1:0] light_y_ff, light_y_in;

   logic                    prev_valid_ff, prev_valid_in;
   logic signed [VTX_W-1:0] prev_vx_ff, prev_vx_in;
   logic signed [VTX_W-1:0] prev_vy_ff, prev_vy_in;
   logic signed [DLT_W-1:0] prev_dx_ff, prev_dx_in;
   logic signed [DLT_W-1:0] prev_dy_ff, prev_dy_in;
   logic [CRN_W-1:0]        prev_fx_ff, prev_fx_in;
   logic [CRN_W-1:0]        prev_fy_ff, prev_fy_in;

   logic signed [VTX_W-1:0] vx_ff, vx_in;
   logic signed [VTX_W-1:0] vy_ff, vy_in;
   logic                    start_ff, start_in;
   logic [COL_W-1:0]        color_ff, color_in;
   logic signed [DLT_W-1:0] dx_ff, dx_in;
   logic signed [DLT_W-1:0] dy_ff, dy_in;
   logic [LEN_W-1:0]        len_ff, len_in;
   logic                    valid_ff, valid_in;
   logic [CRN_W-1:0]        fx_ff, fx_in;
   logic [CRN_W-1:0]        fy_ff, fy_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   logic [QUO_W-1:0]        quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic                    div_y_ff, div_y_in;
   logic signed [PROD_W-1:0] prod_a_ff, prod_a_in;
   logic signed [PROD_W-1:0] prod_b_ff, prod_b_in;
   logic [1:0]              corner_ff, corner_in;

   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [CRN_W-1:0]        rsp_x_ff, rsp_x_in;
   logic [CRN_W-1:0]        rsp_y_ff, rsp_y_in;
   logic [COL_W-1:0]        rsp_col_ff, rsp_col_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic                    req_accept;
   logic signed [VTX_W-1:0] req_vx;
   logic signed [VTX_W-1:0] req_vy;
   logic [DLT_W-1:0]        abs_dx;
   logic [DLT_W-1:0]        abs_dy;
   logic [LEN_W-1:0]        len_sum;
   logic                    div_ge;
   logic [REM_W-1:0]        div_diff;
   logic [REM_W-1:0]        rem_after;
   logic [QUO_W-1:0]        quo_next;
   logic                    div_last;
   logic                    div_neg;
   logic signed [VTX_W-1:0] div_v;
   logic [CRN_W-1:0]        q_ext;
   logic [CRN_W-1:0]        far_off;
   logic [CRN_W-1:0]        far_calc;
   logic signed [DLT_W-1:0] mul_a;
   logic signed [DLT_W-1:0] mul_b;
   logic signed [PROD_W-1:0] product;
   logic                    prev_ok;
   logic                    rsp_load;
   logic [CRN_W-1:0]        corner_x;
   logic [CRN_W-1:0]        corner_y;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   assign req_vx = req_tdata[VTX_W-1:0];
   assign req_vy = req_tdata[2*VTX_W-1:VTX_W];

   assign abs_dx  = dx_ff[DLT_W-1] ? (~dx_ff + DLT_W'(1)) : dx_ff;
   assign abs_dy  = dy_ff[DLT_W-1] ? (~dy_ff + DLT_W'(1)) : dy_ff;
   assign len_sum = LEN_W'(abs_dx) + LEN_W'(abs_dy);

   // restoring divider step, shared between both axes
   assign div_ge    = rem_ff >= REM_W'(len_ff);
   assign div_diff  = rem_ff - REM_W'(len_ff);
   assign rem_after = div_ge ? div_diff : rem_ff;
   assign quo_next  = {quo_ff[QUO_W-2:0], div_ge};
   assign div_last  = (cnt_ff == CNT_W'(QUO_W - 1));
   assign div_neg   = div_y_ff ? dy_ff[DLT_W-1] : dx_ff[DLT_W-1];
   assign div_v     = div_y_ff ? vy_ff : vx_ff;
   assign q_ext     = CRN_W'(quo_next);
   assign far_off   = div_neg ? (~q_ext + CRN_W'(1)) : q_ext;
   assign far_calc  = CRN_W'(div_v) + far_off;

   // shared multiplier for both cross product terms, signed 31 x 31
   assign mul_a   = (state_ff == ST_MUL_A) ? prev_dx_ff : prev_dy_ff;
   assign mul_b   = (state_ff == ST_MUL_A) ? dy_ff : dx_ff;
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign prev_ok  = prev_valid_ff && !start_ff;
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_tvalid_ff || rsp_tready);

   always_comb begin
      corner_x = CRN_W'(vx_ff);
      corner_y = CRN_W'(vy_ff);
      case (corner_ff)
         CORNER_PREV_VTX: begin
            corner_x = CRN_W'(prev_vx_ff);
            corner_y = CRN_W'(prev_vy_ff);
         end
         CORNER_PREV_FAR: begin
            corner_x = prev_fx_ff;
            corner_y = prev_fy_ff;
         end
         CORNER_CUR_FAR: begin
            corner_x = fx_ff;
            corner_y = fy_ff;
         end
         default: begin
            corner_x = CRN_W'(vx_ff);
            corner_y = CRN_W'(vy_ff);
         end
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      light_x_in    = light_x_ff;
      light_y_in    = light_y_ff;
      prev_valid_in = prev_valid_ff;
      prev_vx_in    = prev_vx_ff;
      prev_vy_in    = prev_vy_ff;
      prev_dx_in    = prev_dx_ff;
      prev_dy_in    = prev_dy_ff;
      prev_fx_in    = prev_fx_ff;
      prev_fy_in    = prev_fy_ff;
      vx_in         = vx_ff;
      vy_in         = vy_ff;
      start_in      = start_ff;
      color_in      = color_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      len_in        = len_ff;
      valid_in      = valid_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      cnt_in        = cnt_ff;
      div_y_in      = div_y_ff;
      prod_a_in     = prod_a_ff;
      prod_b_in     = prod_b_ff;
      corner_in     = corner_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_last_in   = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_LIGHT_X: light_x_in = csr_data;
            REG_LIGHT_Y: light_y_in = csr_data;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               vx_in    = req_vx;
               vy_in    = req_vy;
               start_in = req_tuser;
               color_in = req_tdata[2*VTX_W+COL_W-1:2*VTX_W];
               dx_in    = DLT_W'(req_vx) - DLT_W'(light_x_ff);
               dy_in    = DLT_W'(req_vy) - DLT_W'(light_y_ff);
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            len_in   = len_sum;
            rem_in   = REM_W'(abs_dx);
            quo_in   = '0;
            cnt_in   = '0;
            div_y_in = 1'b0;
            if (len_sum >= MIN_LEN) begin
               valid_in = 1'b1;
               state_in = ST_DIV;
            end else begin
               // too close to the light: no far point, no quad
               valid_in = 1'b0;
               fx_in    = '0;
               fy_in    = '0;
               state_in = ST_CMP;
            end
         end
         ST_DIV: begin
            rem_in = {rem_after[REM_W-2:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff + CNT_W'(1);
            if (div_last) begin
               cnt_in = '0;
               quo_in = '0;
               if (div_y_ff) begin
                  fy_in    = far_calc;
                  state_in = ST_MUL_A;
               end else begin
                  fx_in    = far_calc;
                  rem_in   = REM_W'(abs_dy);
                  div_y_in = 1'b1;
               end
            end
         end
         ST_MUL_A: begin
            prod_a_in = product;
            state_in  = ST_MUL_B;
         end
         ST_MUL_B: begin
            prod_b_in = product;
            state_in  = ST_CMP;
         end
         ST_CMP: begin
            corner_in = CORNER_PREV_VTX;
            // cross product negative when prev_dx*dy < prev_dy*dx
            if (prev_ok && valid_ff && (prod_a_ff < prod_b_ff)) begin
               state_in = ST_EMIT;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_tvalid_in = 1'b1;
               rsp_x_in      = corner_x;
               rsp_y_in      = corner_y;
               rsp_col_in    = color_ff;
               rsp_last_in   = (corner_ff == CORNER_CUR_VTX);
               corner_in     = corner_ff + 2'd1;
               if (corner_ff == CORNER_CUR_VTX) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // the current vertex becomes the previous one as the item finishes
      if (state_ff != ST_IDLE && state_in == ST_IDLE) begin
         prev_valid_in = valid_ff;
         prev_vx_in    = vx_ff;
         prev_vy_in    = vy_ff;
         prev_dx_in    = dx_ff;
         prev_dy_in    = dy_ff;
         prev_fx_in    = fx_ff;
         prev_fy_in    = fy_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         light_x_ff    <= '0;
         light_y_ff    <= '0;
         prev_valid_ff <= 1'b0;
         prev_vx_ff    <= '0;
         prev_vy_ff    <= '0;
         prev_dx_ff    <= '0;
         prev_dy_ff    <= '0;
         prev_fx_ff    <= '0;
         prev_fy_ff    <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         light_x_ff    <= light_x_in;
         light_y_ff    <= light_y_in;
         prev_valid_ff <= prev_valid_in;
         prev_vx_ff    <= prev_vx_in;
         prev_vy_ff    <= prev_vy_in;
         prev_dx_ff    <= prev_dx_in;
         prev_dy_ff    <= prev_dy_in;
         prev_fx_ff    <= prev_fx_in;
         prev_fy_ff    <= prev_fy_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      vx_ff       <= vx_in;
      vy_ff       <= vy_in;
      start_ff    <= start_in;
      color_ff    <= color_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      len_ff      <= len_in;
      valid_ff    <= valid_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      rem_ff      <= rem_in;
      quo_ff      <= quo_in;
      cnt_ff      <= cnt_in;
      div_y_ff    <= div_y_in;
      prod_a_ff   <= prod_a_in;
      prod_b_ff   <= prod_b_in;
      corner_ff   <= corner_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {rsp_col_ff, rsp_y_ff, rsp_x_ff};
   assign rsp_tlast  = rsp_last_ff;

   // partial remainder stays below twice the divisor
   `ASSERT_NEVER(a_div_rem_bound, clock, reset,
      (state_ff == ST_DIV) && (rem_ff >= {len_ff, 1'b0}))
   // the divider only runs on lengths of MIN_LEN or more
   `ASSERT_NEVER(a_div_len_min, clock, reset, (state_ff == ST_DIV) && (len_ff < MIN_LEN))
   // a new corner is only loaded from the output phase
   `ASSERT_PROP(a_rsp_from_emit, clock, reset,
      $rose(rsp_tvalid_ff) |-> $past(state_ff) == ST_EMIT)
   // loading the fourth corner ends the item with tlast set
   `ASSERT_PROP(a_last_ends_item, clock, reset,
      (rsp_load && corner_ff == CORNER_CUR_VTX) |=> (state_ff == ST_IDLE) && rsp_last_ff)

endmodule
